FILE: src/ttrr_pkg.sv
// Package for the round-robin thread table: codes, reset values, shared types.
// No dependencies; used by every module of the block.
package ttrr_pkg;

  localparam int THREAD_SLOTS_DEF = 16;
  localparam int ADDR_W           = 32;
  localparam int WORDS_W          = 17;
  localparam int SLOT_W           = 4;
  localparam int CFG_IDX_W        = 2;

  localparam logic [ADDR_W-1:0]  WORD_BYTES    = 32'd4;
  localparam logic [ADDR_W-1:0]  RST_FIRST_TOP = 32'd536879104;
  localparam logic [ADDR_W-1:0]  RST_FIRST_BOT = 32'd536875008;
  localparam logic [WORDS_W-1:0] RST_WORDS     = 17'd1024;

  typedef enum logic [1:0] {
    OP_INIT,
    OP_CREATE,
    OP_LOG,
    OP_SWITCH
  } op_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_FULL,
    ST_NO_MATCH
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_TOP,
    CFG_FIRST_BOTTOM,
    CFG_STACK_WORDS
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CR_CALC,
    S_CR_WR,
    S_LOG,
    S_SW_RD,
    S_SW_OUT
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  first_top;
    logic [ADDR_W-1:0]  first_bottom;
    logic [WORDS_W-1:0] stack_words;
  } cfg_t;

endpackage

FILE: src/ttrr_mem.sv
// Slot memory: one entry per slot holding {stack top, stack bottom}.
// Depends on ttrr_pkg. One read port with registered data, one write port.
module ttrr_mem #(
  parameter int DEPTH = ttrr_pkg::THREAD_SLOTS_DEF,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ttrr_pkg::mem_ctl_t          ctl,
  input  logic [IDX_W-1:0]            rd_idx,
  input  logic [IDX_W-1:0]            wr_idx,
  input  logic [ttrr_pkg::ADDR_W-1:0] wr_top,
  input  logic [ttrr_pkg::ADDR_W-1:0] wr_bot,
  output logic [ttrr_pkg::ADDR_W-1:0] rd_top,
  output logic [ttrr_pkg::ADDR_W-1:0] rd_bot
);

  logic [2*ttrr_pkg::ADDR_W-1:0] mem [DEPTH];
  logic [2*ttrr_pkg::ADDR_W-1:0] rd_data;
  logic                          entry0_written;
  logic                          rd_dflt;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_idx] <= {wr_top, wr_bot};
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

  // entry 0 reads as the reset thread until first written
  always_ff @(posedge clk) begin
    if (rst) begin
      entry0_written <= 1'b0;
      rd_dflt        <= 1'b0;
    end else begin
      if (ctl.wr_en && (wr_idx == '0)) begin
        entry0_written <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_dflt <= (rd_idx == '0) && !entry0_written;
      end
    end
  end

  assign rd_top = rd_dflt ? ttrr_pkg::RST_FIRST_TOP
                          : rd_data[2*ttrr_pkg::ADDR_W-1:ttrr_pkg::ADDR_W];
  assign rd_bot = rd_dflt ? ttrr_pkg::RST_FIRST_BOT : rd_data[ttrr_pkg::ADDR_W-1:0];

endmodule

FILE: src/ttrr_ctrl.sv
// Sequencer for init, create, log and switch; holds used flags and thread state.
// Depends on ttrr_pkg; drives the slot memory in ttrr_mem.
module ttrr_ctrl #(
  parameter int SLOTS = ttrr_pkg::THREAD_SLOTS_DEF,
  localparam int IDX_W = $clog2(SLOTS),
  localparam int CNT_W = $clog2(SLOTS + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  op,
  input  logic [ttrr_pkg::ADDR_W-1:0] addr,
  input  ttrr_pkg::cfg_t              cfg,
  output ttrr_pkg::mem_ctl_t          mem_ctl,
  output logic [IDX_W-1:0]            mem_rd_idx,
  output logic [IDX_W-1:0]            mem_wr_idx,
  output logic [ttrr_pkg::ADDR_W-1:0] mem_wr_top,
  output logic [ttrr_pkg::ADDR_W-1:0] mem_wr_bot,
  input  logic [ttrr_pkg::ADDR_W-1:0] mem_rd_top,
  input  logic [ttrr_pkg::ADDR_W-1:0] mem_rd_bot,
  output logic                        done,
  output logic [ttrr_pkg::ADDR_W-1:0] stack_addr,
  output logic [ttrr_pkg::SLOT_W-1:0] slot,
  output logic [1:0]                  status
);

  ttrr_pkg::state_t state, state_next;

  logic [SLOTS-1:0]            used, used_next;
  logic [ttrr_pkg::ADDR_W-1:0] next_free, next_free_next;
  logic [IDX_W-1:0]            cur, cur_next;
  logic [CNT_W-1:0]            active, active_next;
  logic [ttrr_pkg::ADDR_W-1:0] addr_r, addr_r_next;
  logic [ttrr_pkg::ADDR_W-1:0] bottom_r, bottom_r_next;
  logic [IDX_W-1:0]            free_r, free_r_next;
  logic [CNT_W-1:0]            issue, issue_next;
  logic                        p_vld, p_vld_next;
  logic [IDX_W-1:0]            p_idx, p_idx_next;
  logic                        done_next;
  logic [ttrr_pkg::ADDR_W-1:0] res_addr, res_addr_next;
  logic [ttrr_pkg::SLOT_W-1:0] res_slot, res_slot_next;
  ttrr_pkg::status_t           res_status, res_status_next;

  logic                        accept;
  logic [IDX_W-1:0]            free_idx;
  logic                        full;
  logic [ttrr_pkg::ADDR_W-1:0] words_bytes;
  logic                        match;
  logic [CNT_W-1:0]            cur_inc;

  assign busy   = (state != ttrr_pkg::S_IDLE);
  assign accept = start && !busy;
  assign full   = &used;

  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign words_bytes = {(ttrr_pkg::ADDR_W - ttrr_pkg::WORDS_W - 2)'(0), cfg.stack_words, 2'b00};
  assign match   = used[p_idx] && (addr_r <= mem_rd_top) && (addr_r >= mem_rd_bot);
  assign cur_inc = CNT_W'(cur) + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ttrr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    used_next       = used;
    next_free_next  = next_free;
    cur_next        = cur;
    active_next     = active;
    addr_r_next     = addr_r;
    bottom_r_next   = bottom_r;
    free_r_next     = free_r;
    issue_next      = issue;
    p_vld_next      = 1'b0;
    p_idx_next      = p_idx;
    done_next       = 1'b0;
    res_addr_next   = res_addr;
    res_slot_next   = res_slot;
    res_status_next = res_status;
    mem_ctl         = '0;
    mem_rd_idx      = cur;
    mem_wr_idx      = '0;
    mem_wr_top      = cfg.first_top;
    mem_wr_bot      = cfg.first_bottom;

    unique case (state)
      ttrr_pkg::S_IDLE: begin
        if (accept) begin
          addr_r_next = addr;
          issue_next  = '0;
          unique case (ttrr_pkg::op_t'(op))
            ttrr_pkg::OP_INIT: begin
              mem_ctl.wr_en   = 1'b1;
              used_next       = SLOTS'(1);
              next_free_next  = cfg.first_bottom - ttrr_pkg::WORD_BYTES;
              cur_next        = '0;
              active_next     = CNT_W'(1);
              done_next       = 1'b1;
              res_addr_next   = '0;
              res_slot_next   = '0;
              res_status_next = ttrr_pkg::ST_OK;
            end
            ttrr_pkg::OP_CREATE: state_next = ttrr_pkg::S_CR_CALC;
            ttrr_pkg::OP_LOG:    state_next = ttrr_pkg::S_LOG;
            ttrr_pkg::OP_SWITCH: state_next = ttrr_pkg::S_SW_RD;
            default:             state_next = ttrr_pkg::S_IDLE;
          endcase
        end
      end
      ttrr_pkg::S_CR_CALC: begin
        if (full) begin
          done_next       = 1'b1;
          res_addr_next   = '0;
          res_slot_next   = '0;
          res_status_next = ttrr_pkg::ST_FULL;
          state_next      = ttrr_pkg::S_IDLE;
        end else begin
          bottom_r_next = next_free - words_bytes;
          free_r_next   = free_idx;
          state_next    = ttrr_pkg::S_CR_WR;
        end
      end
      ttrr_pkg::S_CR_WR: begin
        mem_ctl.wr_en         = 1'b1;
        mem_wr_idx            = free_r;
        mem_wr_top            = next_free;
        mem_wr_bot            = bottom_r;
        used_next[free_r]     = 1'b1;
        next_free_next        = bottom_r - ttrr_pkg::WORD_BYTES;
        if (active < CNT_W'(SLOTS)) begin
          active_next = active + CNT_W'(1);
        end
        done_next       = 1'b1;
        res_addr_next   = next_free;
        res_slot_next   = ttrr_pkg::SLOT_W'(free_r);
        res_status_next = ttrr_pkg::ST_OK;
        state_next      = ttrr_pkg::S_IDLE;
      end
      ttrr_pkg::S_LOG: begin
        // reads issue one per cycle; the compare follows in the cycle after each read
        mem_rd_idx = issue[IDX_W-1:0];
        if (issue < active) begin
          mem_ctl.rd_en = 1'b1;
          p_vld_next    = 1'b1;
          p_idx_next    = issue[IDX_W-1:0];
          issue_next    = issue + CNT_W'(1);
        end
        if (p_vld && match) begin
          mem_ctl.wr_en   = 1'b1;
          mem_wr_idx      = p_idx;
          mem_wr_top      = addr_r;
          mem_wr_bot      = mem_rd_bot;
          done_next       = 1'b1;
          res_addr_next   = '0;
          res_slot_next   = ttrr_pkg::SLOT_W'(p_idx);
          res_status_next = ttrr_pkg::ST_OK;
          state_next      = ttrr_pkg::S_IDLE;
        end else if (!mem_ctl.rd_en && !p_vld) begin
          done_next       = 1'b1;
          res_addr_next   = '0;
          res_slot_next   = '0;
          res_status_next = ttrr_pkg::ST_NO_MATCH;
          state_next      = ttrr_pkg::S_IDLE;
        end
      end
      ttrr_pkg::S_SW_RD: begin
        mem_ctl.rd_en = 1'b1;
        state_next    = ttrr_pkg::S_SW_OUT;
      end
      ttrr_pkg::S_SW_OUT: begin
        cur_next        = (cur_inc == active) ? '0 : cur_inc[IDX_W-1:0];
        done_next       = 1'b1;
        res_addr_next   = mem_rd_top;
        res_slot_next   = ttrr_pkg::SLOT_W'(cur);
        res_status_next = ttrr_pkg::ST_OK;
        state_next      = ttrr_pkg::S_IDLE;
      end
      default: state_next = ttrr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= SLOTS'(1);
      next_free <= ttrr_pkg::RST_FIRST_BOT - ttrr_pkg::WORD_BYTES;
      cur       <= '0;
      active    <= CNT_W'(1);
      p_vld     <= 1'b0;
      done      <= 1'b0;
    end else begin
      used      <= used_next;
      next_free <= next_free_next;
      cur       <= cur_next;
      active    <= active_next;
      p_vld     <= p_vld_next;
      done      <= done_next;
    end
    addr_r     <= addr_r_next;
    bottom_r   <= bottom_r_next;
    free_r     <= free_r_next;
    issue      <= issue_next;
    p_idx      <= p_idx_next;
    res_addr   <= res_addr_next;
    res_slot   <= res_slot_next;
    res_status <= res_status_next;
  end

  assign stack_addr = res_addr;
  assign slot       = res_slot;
  assign status     = res_status;

endmodule

FILE: src/thread_table_round_robin.sv
// Top level of the round-robin thread table: config registers, sequencer, slot memory.
// Depends on ttrr_pkg, ttrr_ctrl and ttrr_mem.
//
// channel   signals                          direction  handshake
// config    cfg_we, cfg_idx, cfg_data        in         taken when cfg_we high
// request   start, busy, op, addr            in         taken when start && !busy
// result    done, stack_addr, slot, status   out        done high for one cycle
//
// Init ends in idle, create runs S_CR_CALC and S_CR_WR, switch S_SW_RD and S_SW_OUT;
// log walks the used slots through the single memory read port, one per cycle.
// Result registers show the answer in the cycle after the last step.
// Synchronous reset restores slot 0 and the register defaults; no clearing pass.
// The result side cannot stall; a new request may start while done is high.
module thread_table_round_robin #(
  parameter int THREAD_SLOTS = ttrr_pkg::THREAD_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ttrr_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [ttrr_pkg::ADDR_W-1:0]    cfg_data,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     op,
  input  logic [ttrr_pkg::ADDR_W-1:0]    addr,
  output logic                           done,
  output logic [ttrr_pkg::ADDR_W-1:0]    stack_addr,
  output logic [ttrr_pkg::SLOT_W-1:0]    slot,
  output logic [1:0]                     status
);

  localparam int IDX_W = $clog2(THREAD_SLOTS);

  ttrr_pkg::cfg_t              cfg;
  ttrr_pkg::mem_ctl_t          mem_ctl;
  logic [IDX_W-1:0]            mem_rd_idx;
  logic [IDX_W-1:0]            mem_wr_idx;
  logic [ttrr_pkg::ADDR_W-1:0] mem_wr_top;
  logic [ttrr_pkg::ADDR_W-1:0] mem_wr_bot;
  logic [ttrr_pkg::ADDR_W-1:0] mem_rd_top;
  logic [ttrr_pkg::ADDR_W-1:0] mem_rd_bot;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_top    <= ttrr_pkg::RST_FIRST_TOP;
      cfg.first_bottom <= ttrr_pkg::RST_FIRST_BOT;
      cfg.stack_words  <= ttrr_pkg::RST_WORDS;
    end else if (cfg_we) begin
      case (ttrr_pkg::cfg_reg_t'(cfg_idx))
        ttrr_pkg::CFG_FIRST_TOP:    cfg.first_top    <= cfg_data;
        ttrr_pkg::CFG_FIRST_BOTTOM: cfg.first_bottom <= cfg_data;
        ttrr_pkg::CFG_STACK_WORDS:  cfg.stack_words  <= cfg_data[ttrr_pkg::WORDS_W-1:0];
        default: ;
      endcase
    end
  end

  ttrr_ctrl #(
    .SLOTS(THREAD_SLOTS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .op         (op),
    .addr       (addr),
    .cfg        (cfg),
    .mem_ctl    (mem_ctl),
    .mem_rd_idx (mem_rd_idx),
    .mem_wr_idx (mem_wr_idx),
    .mem_wr_top (mem_wr_top),
    .mem_wr_bot (mem_wr_bot),
    .mem_rd_top (mem_rd_top),
    .mem_rd_bot (mem_rd_bot),
    .done       (done),
    .stack_addr (stack_addr),
    .slot       (slot),
    .status     (status)
  );

  ttrr_mem #(
    .DEPTH(THREAD_SLOTS)
  ) u_mem (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mem_ctl),
    .rd_idx (mem_rd_idx),
    .wr_idx (mem_wr_idx),
    .wr_top (mem_wr_top),
    .wr_bot (mem_wr_bot),
    .rd_top (mem_rd_top),
    .rd_bot (mem_rd_bot)
  );

endmodule
